FILE: rtl/core/prc_pkg.sv
`default_nettype none

package prc_pkg;

  // Default graph size; the node fields on the stream are fixed at five bits.
  localparam int NODE_COUNT_DEF = 26;

  localparam int NODE_IN_W   = 5;
  localparam int WEIGHT_W    = 10;
  localparam int COST_W      = 24;
  localparam int SUM_W       = COST_W + 1;
  localparam int DIST_W      = 20;
  localparam int STATUS_W    = 2;

  localparam int IN_TDATA_W  = 24;
  localparam int OUT_TDATA_W = 32;

  localparam logic [COST_W-1:0] COST_MAX = {COST_W{1'b1}};

  // Parity status codes.
  localparam logic [STATUS_W-1:0] STAT_NONE  = 2'd0;
  localparam logic [STATUS_W-1:0] STAT_PAIR  = 2'd1;
  localparam logic [STATUS_W-1:0] STAT_OTHER = 2'd2;

  typedef struct packed {
    logic                cost_saturated;
    logic                path_unreachable;
    logic [STATUS_W-1:0] parity_status;
    logic [COST_W-1:0]   route_cost;
  } res_t;

endpackage

`default_nettype wire

FILE: rtl/core/prc_adj_ram.sv
`default_nettype none

module prc_adj_ram #(
  parameter int DEPTH  = 676,
  parameter int ADDR_W = 10
) (
  input  wire logic                          clk,
  input  wire logic                          we,
  input  wire logic [ADDR_W-1:0]             waddr,
  input  wire logic [prc_pkg::WEIGHT_W-1:0]  wdata,
  input  wire logic [ADDR_W-1:0]             raddr,
  output logic      [prc_pkg::WEIGHT_W-1:0]  rdata
);
  import prc_pkg::*;

  logic [WEIGHT_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

FILE: rtl/core/prc_dist_ram.sv
`default_nettype none

module prc_dist_ram #(
  parameter int DEPTH  = 26,
  parameter int ADDR_W = 5
) (
  input  wire logic                        clk,
  input  wire logic                        we,
  input  wire logic [ADDR_W-1:0]           waddr,
  input  wire logic [prc_pkg::DIST_W-1:0]  wdata,
  input  wire logic [ADDR_W-1:0]           raddr_a,
  input  wire logic [ADDR_W-1:0]           raddr_b,
  output logic      [prc_pkg::DIST_W-1:0]  rdata_a,
  output logic      [prc_pkg::DIST_W-1:0]  rdata_b
);
  import prc_pkg::*;

  logic [DIST_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end

endmodule

`default_nettype wire

FILE: rtl/core/prc_ctrl.sv
`default_nettype none

module prc_ctrl #(
  parameter int NODE_COUNT = prc_pkg::NODE_COUNT_DEF,
  parameter int NODE_W     = $clog2(NODE_COUNT),
  parameter int ADDR_W     = $clog2(NODE_COUNT * NODE_COUNT)
) (
  input  wire logic                          clk,
  input  wire logic                          rst,
  // edge request
  input  wire logic                          in_valid,
  output logic                               in_ready,
  input  wire logic [prc_pkg::NODE_IN_W-1:0] from_node,
  input  wire logic [prc_pkg::NODE_IN_W-1:0] to_node,
  input  wire logic [prc_pkg::WEIGHT_W-1:0]  edge_weight,
  input  wire logic                          last_edge,
  // result hand-off
  output logic                               res_valid,
  input  wire logic                          res_ready,
  output prc_pkg::res_t                      res,
  // adjacency store
  output logic                               adj_we,
  output logic      [ADDR_W-1:0]             adj_waddr,
  output logic      [prc_pkg::WEIGHT_W-1:0]  adj_wdata,
  output logic      [ADDR_W-1:0]             adj_raddr,
  input  wire logic [prc_pkg::WEIGHT_W-1:0]  adj_rdata,
  // distance store
  output logic                               dist_we,
  output logic      [NODE_W-1:0]             dist_waddr,
  output logic      [prc_pkg::DIST_W-1:0]    dist_wdata,
  output logic      [NODE_W-1:0]             dist_raddr_a,
  output logic      [NODE_W-1:0]             dist_raddr_b,
  input  wire logic [prc_pkg::DIST_W-1:0]    dist_rdata_a,
  input  wire logic [prc_pkg::DIST_W-1:0]    dist_rdata_b
);
  import prc_pkg::*;

  localparam int RND_W = $clog2(NODE_COUNT);
  localparam logic [NODE_W-1:0] NODE_LAST = NODE_W'(NODE_COUNT - 1);
  localparam logic [RND_W-1:0]  RND_LAST  = RND_W'(NODE_COUNT - 1);
  localparam logic [RND_W-1:0]  RND_FIRST = RND_W'(1);
  localparam logic [ADDR_W-1:0] ADDR_LAST = ADDR_W'(NODE_COUNT * NODE_COUNT - 1);
  localparam logic [NODE_COUNT-1:0] ONE_HOT0 = {{(NODE_COUNT-1){1'b0}}, 1'b1};

  typedef enum logic [3:0] {
    ST_CLR, ST_IDLE, ST_WR2, ST_SCAN, ST_INIT,
    ST_RELAX, ST_DRAIN, ST_RDST, ST_SUM, ST_EMIT
  } state_t;

  state_t state;

  logic [NODE_W-1:0]   u, v, u_q, v_q, n, src, dst;
  logic [ADDR_W-1:0]   addr, wr2_addr;
  logic [RND_W-1:0]    round;
  logic                relax_en, last_q, iss_valid;
  logic [WEIGHT_W-1:0] wr2_w;
  logic [NODE_COUNT-1:0] parity, reached;
  logic [COST_W-1:0]   total;
  logic                tot_sat;
  logic [1:0]          odd_cnt;
  logic                fwd_en;
  logic [NODE_W-1:0]   fwd_addr;
  logic [DIST_W-1:0]   fwd_data;

  // combinational helpers
  logic                ends_ok, accept, clear_round, dist_upd;
  logic [NODE_W-1:0]   a_idx, b_idx;
  logic [ADDR_W-1:0]   ab_addr, ba_addr;
  logic [SUM_W-1:0]    tot_sum, path_sum;
  logic [NODE_COUNT-1:0] parity_next;
  logic [1:0]          odd_cnt_next;
  logic [DIST_W-1:0]   du, dv, cand;

  always_comb begin
    in_ready  = (state == ST_IDLE);
    accept    = in_valid && in_ready;
    ends_ok   = (32'(from_node) < NODE_COUNT) && (32'(to_node) < NODE_COUNT);
    a_idx     = NODE_W'(from_node);
    b_idx     = NODE_W'(to_node);
    ab_addr   = ADDR_W'(a_idx * NODE_COUNT + b_idx);
    ba_addr   = ADDR_W'(b_idx * NODE_COUNT + a_idx);
    tot_sum   = {1'b0, total} + SUM_W'(edge_weight);

    parity_next        = parity;
    parity_next[a_idx] = ~parity_next[a_idx];
    parity_next[b_idx] = ~parity_next[b_idx];

    odd_cnt_next = odd_cnt;
    if (parity[n] && odd_cnt != 2'd3) begin
      odd_cnt_next = odd_cnt + 2'd1;
    end

    clear_round = !relax_en || (round == RND_LAST);

    adj_we    = 1'b0;
    adj_waddr = addr;
    adj_wdata = '0;
    adj_raddr = addr;
    unique case (state)
      ST_CLR: begin
        adj_we = 1'b1;
      end
      ST_IDLE: begin
        adj_we    = accept && ends_ok;
        adj_waddr = ab_addr;
        adj_wdata = edge_weight;
      end
      ST_WR2: begin
        adj_we    = 1'b1;
        adj_waddr = wr2_addr;
        adj_wdata = wr2_w;
      end
      ST_RELAX: begin
        adj_we = clear_round;
      end
      default: begin
        adj_we = 1'b0;
      end
    endcase

    // relaxation compare, with the previous cycle's distance write forwarded
    du   = (fwd_en && fwd_addr == u_q) ? fwd_data : dist_rdata_a;
    dv   = (fwd_en && fwd_addr == v_q) ? fwd_data : dist_rdata_b;
    cand = du + DIST_W'(adj_rdata);
    dist_upd = iss_valid && relax_en && reached[u_q] && (adj_rdata != '0) &&
               (!reached[v_q] || cand < dv);

    dist_raddr_a = u;
    dist_raddr_b = (state == ST_RDST) ? dst : v;
    if (state == ST_INIT) begin
      dist_we    = 1'b1;
      dist_waddr = src;
      dist_wdata = '0;
    end else begin
      dist_we    = dist_upd;
      dist_waddr = v_q;
      dist_wdata = cand;
    end

    path_sum  = {1'b0, total} + SUM_W'(dist_rdata_b);
    res_valid = (state == ST_EMIT);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_CLR;
      addr      <= '0;
      parity    <= '0;
      total     <= '0;
      tot_sat   <= 1'b0;
      iss_valid <= 1'b0;
      fwd_en    <= 1'b0;
    end else begin
      iss_valid <= (state == ST_RELAX);
      u_q       <= u;
      v_q       <= v;
      fwd_en    <= dist_we;
      fwd_addr  <= dist_waddr;
      fwd_data  <= dist_wdata;
      if (dist_upd) begin
        reached[v_q] <= 1'b1;
      end

      unique case (state)
        ST_CLR: begin
          if (addr == ADDR_LAST) begin
            addr  <= '0;
            state <= ST_IDLE;
          end else begin
            addr <= addr + ADDR_W'(1);
          end
        end
        ST_IDLE: begin
          if (accept) begin
            last_q   <= last_edge;
            wr2_addr <= ba_addr;
            wr2_w    <= edge_weight;
            n        <= '0;
            odd_cnt  <= '0;
            if (ends_ok) begin
              parity <= parity_next;
              if (tot_sum[COST_W]) begin
                total   <= COST_MAX;
                tot_sat <= 1'b1;
              end else begin
                total <= tot_sum[COST_W-1:0];
              end
              state <= ST_WR2;
            end else if (last_edge) begin
              state <= ST_SCAN;
            end
          end
        end
        ST_WR2: begin
          state <= last_q ? ST_SCAN : ST_IDLE;
        end
        ST_SCAN: begin
          odd_cnt <= odd_cnt_next;
          if (parity[n] && odd_cnt == 2'd0) begin
            src <= n;
          end
          if (parity[n] && odd_cnt == 2'd1) begin
            dst <= n;
          end
          n <= n + NODE_W'(1);
          if (n == NODE_LAST) begin
            u    <= '0;
            v    <= '0;
            addr <= '0;
            if (odd_cnt_next == 2'd2) begin
              relax_en <= 1'b1;
              state    <= ST_INIT;
            end else begin
              relax_en <= 1'b0;
              round    <= RND_LAST;
              state    <= ST_RELAX;
            end
          end
        end
        ST_INIT: begin
          // Only the source starts out reached.
          reached <= ONE_HOT0 << src;
          round   <= RND_FIRST;
          state   <= ST_RELAX;
        end
        ST_RELAX: begin
          if (v == NODE_LAST) begin
            v <= '0;
            if (u == NODE_LAST) begin
              u     <= '0;
              addr  <= '0;
              round <= round + RND_W'(1);
              if (clear_round) begin
                state <= ST_DRAIN;
              end
            end else begin
              u    <= u + NODE_W'(1);
              addr <= addr + ADDR_W'(1);
            end
          end else begin
            v    <= v + NODE_W'(1);
            addr <= addr + ADDR_W'(1);
          end
        end
        ST_DRAIN: begin
          state <= ST_RDST;
        end
        ST_RDST: begin
          state <= ST_SUM;
        end
        ST_SUM: begin
          if (odd_cnt == 2'd0) begin
            res.parity_status <= STAT_NONE;
          end else if (odd_cnt == 2'd2) begin
            res.parity_status <= STAT_PAIR;
          end else begin
            res.parity_status <= STAT_OTHER;
          end
          if (relax_en && reached[dst] && path_sum[COST_W]) begin
            res.route_cost       <= COST_MAX;
            res.cost_saturated   <= 1'b1;
            res.path_unreachable <= 1'b0;
          end else if (relax_en && reached[dst]) begin
            res.route_cost       <= path_sum[COST_W-1:0];
            res.cost_saturated   <= tot_sat;
            res.path_unreachable <= 1'b0;
          end else begin
            res.route_cost       <= total;
            res.cost_saturated   <= tot_sat;
            res.path_unreachable <= relax_en;
          end
          parity  <= '0;
          total   <= '0;
          tot_sat <= 1'b0;
          state   <= ST_EMIT;
        end
        ST_EMIT: begin
          if (res_ready) begin
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

FILE: rtl/core/postman_route_cost_top.sv
// An ordinary edge request is stored with one adjacency write each way.
// A last edge adds a parity scan over all nodes, then with exactly two odd nodes
// repeated relaxation rounds over every node pair, otherwise a clearing sweep,
// and then the drain, distance-read and sum states that form the result.
// Loading is paced by the single write port; relaxation reads one entry a cycle.
// Reset (rst, synchronous, active high) starts a clearing sweep of the adjacency store.
`default_nettype none

module postman_route_cost_top #(
  parameter int NODE_COUNT = prc_pkg::NODE_COUNT_DEF
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  // Edge requests. s_tdata, from bit 0 up: from_node[4:0], to_node[9:5],
  // edge_weight[19:10], zeros[23:20]. s_tlast carries last_edge.
  input  wire logic                            s_tvalid,
  output logic                                 s_tready,
  input  wire logic [prc_pkg::IN_TDATA_W-1:0]  s_tdata,
  input  wire logic                            s_tlast,
  // Results. m_tdata, from bit 0 up: route_cost[23:0], parity_status[25:24],
  // path_unreachable[26], cost_saturated[27], zeros[31:28].
  output logic                                 m_tvalid,
  input  wire logic                            m_tready,
  output logic      [prc_pkg::OUT_TDATA_W-1:0] m_tdata
);
  import prc_pkg::*;

  localparam int NODE_W = $clog2(NODE_COUNT);
  localparam int ADDR_W = $clog2(NODE_COUNT * NODE_COUNT);

  // The controller owns the sequencing; the two stores below hold the graph
  // (weights, both directions) and the distances found during relaxation.
  logic                res_valid, res_ready;
  res_t                res;
  logic                adj_we;
  logic [ADDR_W-1:0]   adj_waddr, adj_raddr;
  logic [WEIGHT_W-1:0] adj_wdata, adj_rdata;
  logic                dist_we;
  logic [NODE_W-1:0]   dist_waddr, dist_raddr_a, dist_raddr_b;
  logic [DIST_W-1:0]   dist_wdata, dist_rdata_a, dist_rdata_b;

  prc_ctrl #(
    .NODE_COUNT (NODE_COUNT),
    .NODE_W     (NODE_W),
    .ADDR_W     (ADDR_W)
  ) u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (s_tvalid),
    .in_ready     (s_tready),
    .from_node    (s_tdata[NODE_IN_W-1:0]),
    .to_node      (s_tdata[2*NODE_IN_W-1:NODE_IN_W]),
    .edge_weight  (s_tdata[2*NODE_IN_W+WEIGHT_W-1:2*NODE_IN_W]),
    .last_edge    (s_tlast),
    .res_valid    (res_valid),
    .res_ready    (res_ready),
    .res          (res),
    .adj_we       (adj_we),
    .adj_waddr    (adj_waddr),
    .adj_wdata    (adj_wdata),
    .adj_raddr    (adj_raddr),
    .adj_rdata    (adj_rdata),
    .dist_we      (dist_we),
    .dist_waddr   (dist_waddr),
    .dist_wdata   (dist_wdata),
    .dist_raddr_a (dist_raddr_a),
    .dist_raddr_b (dist_raddr_b),
    .dist_rdata_a (dist_rdata_a),
    .dist_rdata_b (dist_rdata_b)
  );

  prc_adj_ram #(
    .DEPTH  (NODE_COUNT * NODE_COUNT),
    .ADDR_W (ADDR_W)
  ) u_adj_ram (
    .clk   (clk),
    .we    (adj_we),
    .waddr (adj_waddr),
    .wdata (adj_wdata),
    .raddr (adj_raddr),
    .rdata (adj_rdata)
  );

  prc_dist_ram #(
    .DEPTH  (NODE_COUNT),
    .ADDR_W (NODE_W)
  ) u_dist_ram (
    .clk     (clk),
    .we      (dist_we),
    .waddr   (dist_waddr),
    .wdata   (dist_wdata),
    .raddr_a (dist_raddr_a),
    .raddr_b (dist_raddr_b),
    .rdata_a (dist_rdata_a),
    .rdata_b (dist_rdata_b)
  );

  // Output register. A finished result sits here until the consumer takes it,
  // so the controller is free to start loading the next graph in the meantime.
  assign res_ready = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (res_ready) begin
      m_tvalid <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      m_tdata <= OUT_TDATA_W'(res);
    end
  end

endmodule

`default_nettype wire

FILE: rtl/core/prc_checker.sv
`default_nettype none

module prc_checker #(
  parameter int NODE_COUNT = prc_pkg::NODE_COUNT_DEF
) (
  input wire logic                             clk,
  input wire logic                             rst,
  input wire logic                             s_tvalid,
  input wire logic                             s_tready,
  input wire logic [prc_pkg::IN_TDATA_W-1:0]   s_tdata,
  input wire logic                             s_tlast,
  input wire logic                             m_tvalid,
  input wire logic                             m_tready,
  input wire logic [prc_pkg::OUT_TDATA_W-1:0]  m_tdata
);
  import prc_pkg::*;

  logic ends_in_range;

  assign ends_in_range = (32'(s_tdata[NODE_IN_W-1:0]) < NODE_COUNT) &&
                         (32'(s_tdata[2*NODE_IN_W-1:NODE_IN_W]) < NODE_COUNT);

  // A waiting result holds until it is taken.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result changed while stalled");

  // A stored edge is followed by its mirrored write, and a last edge
  // starts the scan; only a dropped edge that is not last leaves the input open.
  a_two_cycle: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready && (s_tlast || ends_in_range) |=> !s_tready)
    else $error("edge request taken in consecutive cycles");

  a_status_code: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[25:24] != 2'b11)
    else $error("undefined parity status");

  a_unreach_pair: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[26] |-> m_tdata[25:24] == STAT_PAIR)
    else $error("unreachable flag without an odd pair");

  a_sat_value: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[27] |-> m_tdata[COST_W-1:0] == COST_MAX)
    else $error("saturated result below full scale");

endmodule

bind postman_route_cost_top prc_checker #(
  .NODE_COUNT (NODE_COUNT)
) u_prc_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .s_tdata  (s_tdata),
  .s_tlast  (s_tlast),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);

`default_nettype wire
